/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the list engine.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BLL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define BLL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// invariant
`define BLL_ASSERT_ALW(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

`endif

/* hdl/bll_pkg.sv */
// ---------------------------------------------------------------------------
// bll_pkg
// Types and codes shared by the list engine and its cells.
// ---------------------------------------------------------------------------
package bll_pkg;

   localparam int DATA_W = 32;
   localparam int OP_W   = 3;
   localparam int ST_W   = 2;
   localparam int MODE_W = 3;

   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_REAR  = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_AFTER = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL_REAR  = 3'd4;
   localparam logic [OP_W-1:0] OP_DEL_KEY   = 3'd5;

   localparam logic [ST_W-1:0] ST_OK       = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

   // what a cell does when the wave passes it
   localparam logic [MODE_W-1:0] MODE_PASS      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REAR      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SHIFT_IN  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FIND_INS  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FIND_DEL  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SHIFT_OUT = 3'd5;
   localparam logic [MODE_W-1:0] MODE_DEL_REAR  = 3'd6;
   localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd7;

   typedef struct packed {
      logic              active;
      logic [MODE_W-1:0] mode;
      logic [DATA_W-1:0] carry;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] removed;
      logic              found;
   } wave_type;

endpackage

/* hdl/bll_cell.sv */
// ---------------------------------------------------------------------------
// bll_cell
// One list slot: holds a value and a used flag, acts on the passing wave.
// ---------------------------------------------------------------------------
module bll_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  bll_pkg::wave_type             wave_in,
   output bll_pkg::wave_type             wave_out,
   input  logic [bll_pkg::DATA_W-1:0]    nb_value,
   input  logic                          nb_used,
   output logic [bll_pkg::DATA_W-1:0]    value_out,
   output logic                          used_out
);

   logic [bll_pkg::DATA_W-1:0] val_ff, val_in;
   logic                       used_ff, used_in;
   bll_pkg::wave_type          wave_ff, wave_in_nx;
   logic                       hit;

   assign hit = used_ff && (val_ff == wave_in.key);

   always_comb begin
      val_in     = val_ff;
      used_in    = used_ff;
      wave_in_nx = wave_in;
      if (wave_in.active) begin
         case (wave_in.mode)
            bll_pkg::MODE_PASS: begin
            end
            bll_pkg::MODE_REAR: begin
               if (!used_ff) begin
                  val_in          = wave_in.carry;
                  used_in         = 1'b1;
                  wave_in_nx.mode = bll_pkg::MODE_PASS;
               end
            end
            bll_pkg::MODE_SHIFT_IN: begin
               val_in  = wave_in.carry;
               used_in = 1'b1;
               if (used_ff) begin
                  wave_in_nx.carry = val_ff;
               end else begin
                  wave_in_nx.mode = bll_pkg::MODE_PASS;
               end
            end
            bll_pkg::MODE_FIND_INS: begin
               if (hit) begin
                  wave_in_nx.found = 1'b1;
                  wave_in_nx.mode  = bll_pkg::MODE_SHIFT_IN;
               end
            end
            bll_pkg::MODE_FIND_DEL: begin
               if (hit) begin
                  wave_in_nx.found   = 1'b1;
                  wave_in_nx.removed = val_ff;
                  wave_in_nx.mode    = bll_pkg::MODE_SHIFT_OUT;
                  val_in             = nb_value;
                  used_in            = nb_used;
               end
            end
            bll_pkg::MODE_SHIFT_OUT: begin
               val_in  = nb_value;
               used_in = nb_used;
            end
            bll_pkg::MODE_DEL_REAR: begin
               if (used_ff && !nb_used) begin
                  used_in            = 1'b0;
                  wave_in_nx.found   = 1'b1;
                  wave_in_nx.removed = val_ff;
                  wave_in_nx.mode    = bll_pkg::MODE_PASS;
               end
            end
            bll_pkg::MODE_DEL_FRONT: begin
               wave_in_nx.found   = 1'b1;
               wave_in_nx.removed = val_ff;
               wave_in_nx.mode    = bll_pkg::MODE_SHIFT_OUT;
               val_in             = nb_value;
               used_in            = nb_used;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      if (reset) begin
         used_ff        <= 1'b0;
         wave_ff.active <= 1'b0;
      end else begin
         used_ff <= used_in;
         wave_ff <= wave_in_nx;
      end
   end

   assign wave_out  = wave_ff;
   assign value_out = val_ff;
   assign used_out  = used_ff;

endmodule

/* hdl/bounded_linked_list_engine.sv */
// Commands that walk the list respond once the wave leaves the last cell; full, empty and
// unused-opcode commands respond from the request without launching a wave.
// One request is in flight at a time; req_stall stays high until the response is taken.
// Reset: synchronous active high; list empties on reset, no clearing pass.
// ---------------------------------------------------------------------------
// bounded_linked_list_engine
// Ordered list of signed values held in a row of cells, edited by a wave
// that passes one cell per cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_linked_list_engine #(
   parameter int CAPACITY = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bll_pkg::OP_W-1:0]          req_opcode,
   input  logic signed [bll_pkg::DATA_W-1:0] req_value,
   input  logic signed [bll_pkg::DATA_W-1:0] req_match_key,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bll_pkg::ST_W-1:0]          rsp_status,
   output logic signed [bll_pkg::DATA_W-1:0] rsp_removed_value
);

   bll_pkg::wave_type          chain_w [CAPACITY+1];
   logic [bll_pkg::DATA_W-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]        cell_used;
   logic [CAPACITY:0]          act_vec;

   bll_pkg::wave_type          launch_ff, launch_in;
   logic [bll_pkg::OP_W-1:0]   op_ff, op_in;
   logic                       busy_ff, busy_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [bll_pkg::ST_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [bll_pkg::DATA_W-1:0] rsp_removed_ff, rsp_removed_in;

   logic req_fire, rsp_fire, empty, full;
   bll_pkg::wave_type done_w;

   assign empty    = !cell_used[0];
   assign full     = cell_used[CAPACITY-1];
   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid_ff && !rsp_stall;
   assign done_w   = chain_w[CAPACITY];

   assign chain_w[0] = launch_ff;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [bll_pkg::DATA_W-1:0] nb_value;
         logic                       nb_used;
         if (gi == CAPACITY-1) begin : g_last
            assign nb_value = '0;
            assign nb_used  = 1'b0;
         end else begin : g_mid
            assign nb_value = cell_value[gi+1];
            assign nb_used  = cell_used[gi+1];
         end
         bll_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .wave_in   (chain_w[gi]),
            .wave_out  (chain_w[gi+1]),
            .nb_value  (nb_value),
            .nb_used   (nb_used),
            .value_out (cell_value[gi]),
            .used_out  (cell_used[gi])
         );
      end
      for (gi = 0; gi <= CAPACITY; gi++) begin : g_act
         assign act_vec[gi] = chain_w[gi].active;
      end
   endgenerate

   always_comb begin
      launch_in         = launch_ff;
      launch_in.active  = 1'b0;
      op_in             = op_ff;
      busy_in           = busy_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_removed_in    = rsp_removed_ff;

      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
         busy_in      = 1'b0;
      end

      if (req_fire) begin
         busy_in           = 1'b1;
         op_in             = req_opcode;
         launch_in.carry   = $unsigned(req_value);
         launch_in.key     = $unsigned(req_match_key);
         launch_in.removed = '0;
         launch_in.found   = 1'b0;
         launch_in.mode    = bll_pkg::MODE_PASS;
         rsp_status_in     = bll_pkg::ST_OK;
         rsp_removed_in    = '0;
         case (req_opcode)
            bll_pkg::OP_INS_FRONT, bll_pkg::OP_INS_REAR, bll_pkg::OP_INS_AFTER: begin
               if (full) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bll_pkg::ST_FULL;
               end else begin
                  launch_in.active = 1'b1;
                  if (req_opcode == bll_pkg::OP_INS_FRONT) begin
                     launch_in.mode = bll_pkg::MODE_SHIFT_IN;
                  end else if (req_opcode == bll_pkg::OP_INS_REAR) begin
                     launch_in.mode = bll_pkg::MODE_REAR;
                  end else begin
                     launch_in.mode = bll_pkg::MODE_FIND_INS;
                  end
               end
            end
            bll_pkg::OP_DEL_FRONT, bll_pkg::OP_DEL_REAR, bll_pkg::OP_DEL_KEY: begin
               if (empty) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bll_pkg::ST_EMPTY;
               end else begin
                  launch_in.active = 1'b1;
                  if (req_opcode == bll_pkg::OP_DEL_FRONT) begin
                     launch_in.mode = bll_pkg::MODE_DEL_FRONT;
                  end else if (req_opcode == bll_pkg::OP_DEL_REAR) begin
                     launch_in.mode = bll_pkg::MODE_DEL_REAR;
                  end else begin
                     launch_in.mode = bll_pkg::MODE_FIND_DEL;
                  end
               end
            end
            default: begin
               rsp_valid_in = 1'b1;
            end
         endcase
      end

      if (done_w.active) begin
         rsp_valid_in   = 1'b1;
         rsp_removed_in = done_w.removed;
         if ((op_ff == bll_pkg::OP_INS_AFTER || op_ff == bll_pkg::OP_DEL_KEY)
             && !done_w.found) begin
            rsp_status_in = bll_pkg::ST_NOTFOUND;
         end else begin
            rsp_status_in = bll_pkg::ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      op_ff          <= op_in;
      if (reset) begin
         launch_ff.active <= 1'b0;
         busy_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         launch_ff    <= launch_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall         = busy_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = $signed(rsp_removed_ff);

   `BLL_ASSERT_ALW(a_one_wave, clock, reset, $onehot0(act_vec))
   `BLL_ASSERT_IMP(a_wave_busy, clock, reset, |act_vec, busy_ff && !rsp_valid_ff)
   `BLL_ASSERT_IMP(a_rsp_busy, clock, reset, rsp_valid_ff, busy_ff)
   `BLL_ASSERT_IMP(a_empty_not_full, clock, reset, empty, !full)
   `BLL_ASSERT_NXT(a_done_rsp, clock, reset, done_w.active, rsp_valid_ff)

endmodule
